// ===== hdl/uvt_pkg.sv =====
// Shared types and codes for the unordered value table.
`timescale 1ns / 1ps

package uvt_pkg;

    localparam int CmdW    = 2;
    localparam int ValueW  = 32;
    localparam int StatusW = 2;
    localparam int FoundW  = 4;
    localparam int CountW  = 5;

    localparam int InDataW  = 40;
    localparam int OutDataW = 16;

    typedef enum logic [CmdW-1:0] {
        CMD_APPEND = 2'd0,
        CMD_POP    = 2'd1,
        CMD_LOCATE = 2'd2,
        CMD_REMOVE = 2'd3
    } uvt_cmd_t;

    typedef enum logic [StatusW-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } uvt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_RESP
    } uvt_state_t;

endpackage

// ===== hdl/uvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module uvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/unordered_value_table_unit.sv =====
// Top level of the unordered value table: command sequencer around the entry memory.
`timescale 1ns / 1ps

// The unit keeps an unordered table of up to DEPTH signed 32-bit values in one
// synchronous RAM and answers one request at a time with one result. Append
// stores the value at the end of the table and reports a full table when there
// is no room; pop drops the last entry; locate returns the lowest slot that
// holds the value; remove locates the value, copies the last entry into that
// slot and shrinks the count. Every result carries the entry count after the
// request. Locate and remove read the RAM one slot per cycle through its single
// read port, from slot 0 up to the first hit or the last entry, and a remove
// that must move the last entry then passes through a move state for that copy.
// The next request is taken as soon as the sequencer is back in idle, even
// while the previous result still sits in the output register waiting for the
// consumer. Found index and count are reported in their low 4 and 5 bits.

module unordered_value_table_unit
    import uvt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // From bit 0: command [1:0], value [33:2], zero padding [39:34].
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0: status [1:0], found_index [5:2], entry_count [10:6], zeros [15:11].
    output logic [OutDataW-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    uvt_state_t              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    uvt_cmd_t                cmd_reg, cmd_next;
    logic [ValueW-1:0]       val_reg, val_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic [AW-1:0]           fidx_reg, fidx_next;
    uvt_status_t             stat_reg, stat_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OutDataW-1:0]     m_tdata_reg, m_tdata_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [ValueW-1:0]       mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [ValueW-1:0]       mem_rdata;

    uvt_cmd_t                s_cmd;
    logic [ValueW-1:0]       s_value;
    logic [CW-1:0]           cnt_m1;
    logic [AW-1:0]           last_idx;
    logic [AW+FoundW-1:0]    fidx_ext;
    logic [CW+CountW-1:0]    cnt_ext;

    assign s_cmd    = uvt_cmd_t'(s_tdata[CmdW-1:0]);
    assign s_value  = s_tdata[CmdW+ValueW-1:CmdW];
    assign cnt_m1   = cnt_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    // Widen first so the part-selects work for any table depth.
    assign fidx_ext = {{FoundW{1'b0}}, fidx_reg};
    assign cnt_ext  = {{CountW{1'b0}}, cnt_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    uvt_ram #(
        .WIDTH(ValueW),
        .DEPTH(DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        rd_idx_next   = rd_idx_reg;
        fidx_next     = fidx_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg[AW-1:0];
        mem_wdata     = s_value;
        mem_raddr     = '0;

        // The consumer took the held result.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_cmd;
                    val_next    = s_value;
                    fidx_next   = '0;
                    stat_next   = STAT_OK;
                    rd_idx_next = '0;
                    state_next  = ST_RESP;
                    unique case (s_cmd) inside
                        CMD_APPEND: begin
                            if (cnt_reg == FULL_COUNT) begin
                                stat_next = STAT_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (cnt_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                cnt_next = cnt_m1;
                            end
                        end
                        CMD_LOCATE, CMD_REMOVE: begin
                            if (cnt_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                // Slot 0 is being read; its data arrives in the scan.
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // The read data belongs to the slot in rd_idx_reg.
                if (mem_rdata == val_reg) begin
                    fidx_next = rd_idx_reg;
                    if (cmd_reg == CMD_REMOVE) begin
                        if (rd_idx_reg == last_idx) begin
                            cnt_next   = cnt_m1;
                            state_next = ST_RESP;
                        end else begin
                            mem_raddr  = last_idx;
                            state_next = ST_MOVE;
                        end
                    end else begin
                        state_next = ST_RESP;
                    end
                end else if (rd_idx_reg == last_idx) begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = ST_RESP;
                end else begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                    mem_raddr   = rd_idx_reg + AW'(1);
                end
            end

            ST_MOVE: begin
                // The last entry fills the hole left by the removed value.
                mem_we     = 1'b1;
                mem_waddr  = fidx_reg;
                mem_wdata  = mem_rdata;
                cnt_next   = cnt_m1;
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OutDataW-StatusW-FoundW-CountW){1'b0}},
                                     cnt_ext[CountW-1:0], fidx_ext[FoundW-1:0], stat_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        rd_idx_reg  <= rd_idx_next;
        fidx_reg    <= fidx_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== hdl/uvt_checker.sv =====
// Port-level assertions for the unordered value table, bound to the top level.
`timescale 1ns / 1ps

module uvt_checker
    import uvt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    logic [StatusW-1:0] res_status;
    logic [FoundW-1:0]  res_found;
    logic [CountW-1:0]  res_count;

    assign res_status = m_tdata[StatusW-1:0];
    assign res_found  = m_tdata[StatusW+FoundW-1:StatusW];
    assign res_count  = m_tdata[StatusW+FoundW+CountW-1:StatusW+FoundW];

    // A request keeps the unit busy for at least the following cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on two consecutive cycles");

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty report always comes with a zero count.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status == STAT_EMPTY |-> res_count == '0)
        else $error("empty status with nonzero count");

    // A full report always comes with the count at capacity.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status == STAT_FULL |-> res_count == CountW'(DEPTH))
        else $error("full status with count below capacity");

    // Any failure reports slot zero.
    a_fidx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status != STAT_OK |-> res_found == '0)
        else $error("failed request reported a found slot");

endmodule

bind unordered_value_table_unit uvt_checker #(
    .DEPTH(DEPTH)
) u_uvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/uvt_result_checker.sv =====
// Result checker for the unordered value table: predicts each result and compares it.
`timescale 1ns / 1ps

module uvt_result_checker
    import uvt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // From bit 0: command [1:0], value [33:2], zero padding [39:34].
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0: status [1:0], found_index [5:2], entry_count [10:6], zeros [15:11].
    input  logic [OutDataW-1:0] m_tdata,
    output int                  fail_count,
    output int                  results_awaited
);

    typedef struct packed {
        logic [CountW-1:0] entry_count;
        logic [FoundW-1:0] found_index;
        uvt_status_t       status;
    } table_result_t;

    logic [ValueW-1:0] table_slots [DEPTH];
    int                table_fill;
    table_result_t     awaited_results [$];

    // Applies one request to the shadow table and returns the result it causes.
    task automatic predict_table_result(input uvt_cmd_t cmd, input logic [ValueW-1:0] value,
                                        output table_result_t res);
        int hit;
        res.status      = STAT_OK;
        res.found_index = '0;
        case (cmd)
            CMD_APPEND: begin
                if (table_fill >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    table_slots[table_fill] = value;
                    table_fill++;
                end
            end
            CMD_POP: begin
                if (table_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    table_fill--;
                end
            end
            default: begin
                if (table_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    hit = -1;
                    for (int i = 0; i < table_fill; i++) begin
                        if (hit < 0 && table_slots[i] == value) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        res.status = STAT_NOT_FOUND;
                    end else begin
                        res.found_index = hit[FoundW-1:0];
                        // Remove fills the hole with the last entry and shrinks the table.
                        if (cmd == CMD_REMOVE) begin
                            table_slots[hit] = table_slots[table_fill-1];
                            table_fill--;
                        end
                    end
                end
            end
        endcase
        res.entry_count = table_fill[CountW-1:0];
    endtask

    always @(posedge aclk) begin : watch_channels
        table_result_t actual;
        table_result_t wanted;
        if (!aresetn) begin
            table_fill = 0;
            awaited_results.delete();
        end else begin
            // Results are handled before requests: a result can never belong to
            // the request taken at the same edge.
            if (m_tvalid && m_tready) begin
                actual = table_result_t'(m_tdata[10:0]);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result %h with nothing awaited", $time, m_tdata);
                    fail_count++;
                end else begin
                    wanted = awaited_results.pop_front();
                    if (actual.status !== wanted.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, wanted.status, actual.status);
                        fail_count++;
                    end
                    if (actual.found_index !== wanted.found_index) begin
                        $display("%0t: found_index expected %0d, actual %0d",
                                 $time, wanted.found_index, actual.found_index);
                        fail_count++;
                    end
                    if (actual.entry_count !== wanted.entry_count) begin
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, wanted.entry_count, actual.entry_count);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_table_result(uvt_cmd_t'(s_tdata[1:0]), s_tdata[33:2], wanted);
                awaited_results.push_back(wanted);
            end
        end
        results_awaited = awaited_results.size();
    end

endmodule

// ===== tb/tb_unordered_value_table_unit.sv =====
// Testbench top for the unordered value table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

// The top drives requests into the table and pulls results out of it, both
// with random idle gaps, while the checker beside the block predicts and
// compares every result. Inputs change at the falling edge so that the block
// and the checker see stable values at the rising edge.

module tb_unordered_value_table_unit;
    import uvt_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 750;
    localparam int LONG_HOLD_CYCLES = 300;

    // Phase kinds steer the command mix so the table repeatedly fills and drains.
    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } phase_kind_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    int fail_count;
    int results_awaited;

    // Longest idle gap of each side; zero gives stretches with no idling.
    int src_max_gap  = 19;
    int sink_max_gap = 19;
    // Set by the stimulus to make the result side hold off for a long time.
    int long_hold = 0;

    // Values already appended, so locate and remove mostly hit something.
    logic [ValueW-1:0] value_pool [$];

    always #6 aclk = ~aclk;

    unordered_value_table_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    uvt_result_checker #(
        .DEPTH(DEPTH)
    ) result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .results_awaited(results_awaited)
    );

    // Offers one request and returns at the falling edge after it was taken.
    // The valid line is lowered only when a gap follows, so back-to-back
    // requests keep it high without a second assignment in the same step.
    task automatic send_request(input uvt_cmd_t cmd, input logic [ValueW-1:0] value);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, cmd};
        if (cmd == CMD_APPEND) begin
            value_pool.push_back(value);
            if (value_pool.size() > 24) begin
                void'(value_pool.pop_front());
            end
        end
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Holds the input side idle until every awaited result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_awaited != 0) @(negedge aclk);
    endtask

    // Mostly values already stored, plus small values for duplicates,
    // the extremes of the signed range and fully random words.
    function automatic logic [ValueW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && value_pool.size() > 0) begin
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else if (r == 5) begin
            return ValueW'($urandom_range(0, 7));
        end else if (r == 6) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic uvt_cmd_t pick_command(input phase_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            PHASE_FILL: begin
                if (r < 80) return CMD_APPEND;
                if (r < 87) return CMD_POP;
                if (r < 94) return CMD_LOCATE;
                return CMD_REMOVE;
            end
            PHASE_DRAIN: begin
                if (r < 15) return CMD_APPEND;
                if (r < 40) return CMD_POP;
                if (r < 60) return CMD_LOCATE;
                return CMD_REMOVE;
            end
            default: begin
                if (r < 35) return CMD_APPEND;
                if (r < 50) return CMD_POP;
                if (r < 75) return CMD_LOCATE;
                return CMD_REMOVE;
            end
        endcase
    endfunction

    // Result side: a random wait before each result, or one long hold-off
    // when the stimulus asks for it, counted here in clock cycles.
    initial begin : result_sink
        int wait_cycles;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold > 0) begin
                wait_cycles = long_hold;
                long_hold   = 0;
            end else begin
                wait_cycles = $urandom_range(0, sink_max_gap);
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Guard against a hung handshake.
    initial begin : run_limit
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        phase_kind_t kind;
        int          phase_left;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Pop, locate and remove on an empty table each report it empty.
        send_request(CMD_POP,    32'h0000_0000);
        send_request(CMD_LOCATE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);

        // Extremes of the signed range and a duplicated value.
        send_request(CMD_APPEND, 32'h8000_0000);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        send_request(CMD_APPEND, 32'h0000_0000);
        send_request(CMD_APPEND, 32'hFFFF_FFFF);
        send_request(CMD_APPEND, 32'h0000_0005);
        send_request(CMD_APPEND, 32'h0000_0005);

        // A duplicate is found at its lowest slot; an absent value is not found.
        send_request(CMD_LOCATE, 32'h0000_0005);
        send_request(CMD_LOCATE, 32'hFFFF_FFFF);
        send_request(CMD_LOCATE, 32'h1234_5678);
        send_request(CMD_REMOVE, 32'h1234_5678);

        // Remove from the middle moves the last entry into the hole, then a
        // remove of the entry in the last slot only shrinks the count.
        send_request(CMD_REMOVE, 32'h0000_0005);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF);
        send_request(CMD_LOCATE, 32'h0000_0005);
        send_request(CMD_REMOVE, 32'h0000_0005);
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_POP,    32'hFFFF_FFFF);
        send_request(CMD_LOCATE, 32'h7FFF_FFFF);

        // Random part in phases with their own command mix and idling.
        phase_left = 0;
        kind       = PHASE_FILL;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                phase_left   = $urandom_range(20, 50);
                kind         = phase_kind_t'($urandom_range(0, 2));
                src_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 19;
                sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
            end
            phase_left--;

            // Stall the result side while requests keep coming, so the block
            // fills its output register and then holds off its input.
            if (n == 200) begin
                src_max_gap = 0;
                long_hold   = LONG_HOLD_CYCLES;
            end
            // Let the block run completely dry before going on.
            if (n == 450) begin
                drain_results();
            end

            send_request(pick_command(kind), pick_value());
        end

        drain_results();
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
